// ===== hw/rtl/three_axis_biquad_filter_top_defines.svh =====
// assertion macros for the three-axis biquad filter
`ifndef THREE_AXIS_BIQUAD_FILTER_TOP_DEFINES_SVH
`define THREE_AXIS_BIQUAD_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk with reset masked
`define TBQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define TBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tbq_pkg.sv =====
// types, constants and helper functions for the three-axis biquad filter
package tbq_pkg;

    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int AXIS_AW   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 20;
    localparam int FRAC_W    = 17;
    localparam int COEF_REG_W = 60;
    localparam int DELAY_W   = 40;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int ACC_W     = DELAY_W + 2;
    localparam int DIFF_W    = ACC_W + 1;
    localparam int YFL_W     = ACC_W - FRAC_W;
    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [COEF_W-1:0]     COEF_ONE   = COEF_W'(1) << FRAC_W;
    localparam logic [COEF_REG_W-1:0] COEF_B0_RST = {3{COEF_ONE}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_B0     = 3'd1,
        REG_B1     = 3'd2,
        REG_B2     = 3'd3,
        REG_A1     = 3'd4,
        REG_A2     = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FB1,
        ST_FF2,
        ST_FB2,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_B0_X,
        MUL_B1_X,
        MUL_A1_Y,
        MUL_B2_X,
        MUL_A2_Y
    } mul_sel_t;

    typedef struct packed {
        logic                  enable;
        logic [COEF_REG_W-1:0] b0;
        logic [COEF_REG_W-1:0] b1;
        logic [COEF_REG_W-1:0] b2;
        logic [COEF_REG_W-1:0] a1;
        logic [COEF_REG_W-1:0] a2;
    } tbq_cfg_t;

    typedef struct packed {
        logic signed [DELAY_W-1:0] first;
        logic signed [DELAY_W-1:0] second;
    } delay_pair_t;

    typedef struct packed {
        logic idle;
        logic ram_we;
        logic bypass_pend;
    } tbq_status_t;

    function automatic logic signed [COEF_W-1:0] coef_lane(
        input logic [COEF_REG_W-1:0] r,
        input logic [AXIS_W-1:0]     axis
    );
        logic signed [COEF_W-1:0] v;
        unique case (axis)
            2'd0:    v = r[COEF_W-1:0];
            2'd1:    v = r[2*COEF_W-1:COEF_W];
            default: v = r[3*COEF_W-1:2*COEF_W];
        endcase
        return v;
    endfunction

    function automatic logic axis_ok(input logic [AXIS_W-1:0] axis);
        return ({{(32-AXIS_W){1'b0}}, axis} < AXES);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [YFL_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > YFL_W'(32767))
            r = 16'sh7FFF;
        else if (v < -YFL_W'(32768))
            r = 16'sh8000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat_delay(
        input logic signed [DIFF_W-1:0] v
    );
        logic signed [DELAY_W-1:0] r;
        if (v > DIFF_W'(64'sd549755813887))
            r = {1'b0, {(DELAY_W-1){1'b1}}};
        else if (v < -DIFF_W'(64'sd549755813888))
            r = {1'b1, {(DELAY_W-1){1'b0}}};
        else
            r = v[DELAY_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/tbq_if.sv =====
// valid/ready channel interfaces for samples and results
interface tbq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         axis_sel;
    logic signed [15:0] rate_sample;

    modport source (output valid, output axis_sel, output rate_sample, input ready);
    modport sink   (input valid, input axis_sel, input rate_sample, output ready);
endinterface

interface tbq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] filtered_rate;
    logic               bypassed;

    modport source (output valid, output filtered_rate, output bypassed, input ready);
    modport sink   (input valid, input filtered_rate, input bypassed, output ready);
endinterface

// ===== hw/rtl/tbq_ram.sv =====
// generic single-write, single-read ram with registered read data
module tbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/tbq_regs.sv =====
// apb configuration registers: enable and packed coefficient words
module tbq_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbq_pkg::PADDR_W-1:0]     paddr,
    input  logic [tbq_pkg::PDATA_W-1:0]     pwdata,
    output logic [tbq_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output tbq_pkg::tbq_cfg_t               cfg
);
    import tbq_pkg::*;

    tbq_cfg_t             cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 1'b0;
            cfg_reg.b0     <= COEF_B0_RST;
            cfg_reg.b1     <= '0;
            cfg_reg.b2     <= '0;
            cfg_reg.a1     <= '0;
            cfg_reg.a2     <= '0;
        end
        else if (wr_en)
        begin
            // addresses past the last register are dropped
            unique case (idx)
                REG_ENABLE: cfg_reg.enable <= pwdata[0];
                REG_B0:     cfg_reg.b0     <= pwdata[COEF_REG_W-1:0];
                REG_B1:     cfg_reg.b1     <= pwdata[COEF_REG_W-1:0];
                REG_B2:     cfg_reg.b2     <= pwdata[COEF_REG_W-1:0];
                REG_A1:     cfg_reg.a1     <= pwdata[COEF_REG_W-1:0];
                REG_A2:     cfg_reg.a2     <= pwdata[COEF_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.enable};
            REG_B0:     prdata = {{(PDATA_W-COEF_REG_W){1'b0}}, cfg_reg.b0};
            REG_B1:     prdata = {{(PDATA_W-COEF_REG_W){1'b0}}, cfg_reg.b1};
            REG_B2:     prdata = {{(PDATA_W-COEF_REG_W){1'b0}}, cfg_reg.b2};
            REG_A1:     prdata = {{(PDATA_W-COEF_REG_W){1'b0}}, cfg_reg.a1};
            REG_A2:     prdata = {{(PDATA_W-COEF_REG_W){1'b0}}, cfg_reg.a2};
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/tbq_core.sv =====
// biquad sequencer: delay memory read, shared multiplier, write-back, result register
module tbq_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbq_pkg::tbq_cfg_t    cfg,
    tbq_in_if.sink               sample_in,
    tbq_out_if.source            result_out,
    output tbq_pkg::tbq_status_t status
);
    import tbq_pkg::*;

    state_t state_reg, state_next;

    // control outputs of the sequencer
    logic     accept;
    logic     can_load;
    logic     ram_re;
    logic     ram_we;
    mul_sel_t mul_sel;

    // item registers
    logic [AXIS_W-1:0]          axis_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [COEF_W-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic                       byp_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [DELAY_W-1:0]  d1_reg, d2_reg, d1n_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    sum_reg;
    logic [AXES-1:0]            ent_valid_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_rate_reg;
    logic                       out_byp_reg;

    // datapath
    logic                       in_bypass;
    logic signed [COEF_W-1:0]   mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]    acc;
    logic signed [YFL_W-1:0]    y_floor;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DELAY_W-1:0]  d2_new;
    delay_pair_t                rd_pair;
    delay_pair_t                wr_pair;
    logic [AXIS_AW-1:0]         ent_idx;

    assign in_bypass = !cfg.enable || !axis_ok(sample_in.axis_sel);
    assign can_load  = !out_valid_reg || result_out.ready;
    assign ent_idx   = axis_reg[AXIS_AW-1:0];

    tbq_ram #(
        .WIDTH ($bits(delay_pair_t)),
        .DEPTH (AXES)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ent_idx),
        .wdata (wr_pair),
        .re    (ram_re),
        .raddr (sample_in.axis_sel[AXIS_AW-1:0]),
        .rdata (rd_pair)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_in.valid)
                begin
                    state_next = in_bypass ? ST_DONE : ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: state_next = ST_FB1;
            ST_FB1:   state_next = ST_FF2;
            ST_FF2:   state_next = ST_FB2;
            ST_FB2:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample_in.ready = 1'b0;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        mul_sel         = MUL_B0_X;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_in.ready = 1'b1;
                ram_re          = sample_in.valid && !in_bypass;
            end
            ST_LOAD:  mul_sel = MUL_B0_X;
            ST_ROUND: mul_sel = MUL_B1_X;
            ST_FB1:   mul_sel = MUL_A1_Y;
            ST_FF2:   mul_sel = MUL_B2_X;
            ST_FB2:   mul_sel = MUL_A2_Y;
            ST_DONE:  ram_we  = can_load && !byp_reg;
            default:  ;
        endcase
    end

    assign accept = sample_in.valid && sample_in.ready;

    // one shared multiplier, operands picked by the step
    always_comb
    begin
        unique case (mul_sel)
            MUL_B0_X: begin mul_a = b0_reg; mul_b = x_reg; end
            MUL_B1_X: begin mul_a = b1_reg; mul_b = x_reg; end
            MUL_A1_Y: begin mul_a = a1_reg; mul_b = y_reg; end
            MUL_B2_X: begin mul_a = b2_reg; mul_b = x_reg; end
            MUL_A2_Y: begin mul_a = a2_reg; mul_b = y_reg; end
            default:  begin mul_a = b0_reg; mul_b = x_reg; end
        endcase
    end

    assign mul_p = PROD_W'(mul_a * mul_b);

    // round to nearest by adding one half, then floor
    assign acc     = ACC_W'(prod_reg) + ACC_W'(d1_reg) + ROUND_HALF;
    assign y_floor = YFL_W'(acc >>> FRAC_W);

    assign diff   = DIFF_W'(sum_reg) - DIFF_W'(prod_reg);
    assign d2_new = sat_delay(diff);

    assign wr_pair.first  = d1n_reg;
    assign wr_pair.second = d2_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ent_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                ent_valid_reg[ent_idx] <= 1'b1;
            end
            if (state_reg == ST_DONE && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            axis_reg <= sample_in.axis_sel;
            x_reg    <= sample_in.rate_sample;
            byp_reg  <= in_bypass;
            y_reg    <= sample_in.rate_sample;
            b0_reg   <= coef_lane(cfg.b0, sample_in.axis_sel);
            b1_reg   <= coef_lane(cfg.b1, sample_in.axis_sel);
            b2_reg   <= coef_lane(cfg.b2, sample_in.axis_sel);
            a1_reg   <= coef_lane(cfg.a1, sample_in.axis_sel);
            a2_reg   <= coef_lane(cfg.a2, sample_in.axis_sel);
        end
        unique case (state_reg)
            ST_LOAD:
            begin
                // an entry never written reads as zero
                d1_reg   <= ent_valid_reg[ent_idx] ? rd_pair.first  : '0;
                d2_reg   <= ent_valid_reg[ent_idx] ? rd_pair.second : '0;
                prod_reg <= mul_p;
            end
            ST_ROUND:
            begin
                y_reg    <= sat_sample(y_floor);
                prod_reg <= mul_p;
            end
            ST_FB1:
            begin
                sum_reg  <= ACC_W'(prod_reg) + ACC_W'(d2_reg);
                prod_reg <= mul_p;
            end
            ST_FF2:
            begin
                d1n_reg  <= sat_delay(diff);
                prod_reg <= mul_p;
            end
            ST_FB2:
            begin
                sum_reg  <= ACC_W'(prod_reg);
                prod_reg <= mul_p;
            end
            default: ;
        endcase
        if (state_reg == ST_DONE && can_load)
        begin
            out_rate_reg <= y_reg;
            out_byp_reg  <= byp_reg;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.filtered_rate = out_rate_reg;
    assign result_out.bypassed      = out_byp_reg;

    assign status.idle        = (state_reg == ST_IDLE);
    assign status.ram_we      = ram_we;
    assign status.bypass_pend = (state_reg == ST_DONE) && byp_reg;

endmodule

// ===== hw/rtl/three_axis_biquad_filter_top.sv =====
// top level of the three-axis gyro biquad filter
`include "three_axis_biquad_filter_top_defines.svh"

// Three-axis gyro biquad filter. Each sample on sample_in carries an axis
// number and a signed 16-bit rate; the result on result_out is the filtered,
// rounded and saturated rate, or the raw sample with bypassed set when the
// filter is disabled or the axis is 3. One sample is worked on at a time: a
// filtered sample passes a delay-memory read, five products through one
// shared 20x16 multiplier and a write-back before the next sample transfer;
// a bypassed sample skips these steps. A result left waiting
// in the output register holds the block in its write-back step. Delay state
// for the three axes sits in a small ram and reads as zero after reset until
// an axis is first filtered. Registers are 64-bit APB words at byte address
// 8*index: enable, then b0, b1, b2, a1, a2, each packing three Q2.17 values
// with axis 0 in the low bits; write them only while the block is idle.
module three_axis_biquad_filter_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbq_pkg::PADDR_W-1:0] paddr,
    input  logic [tbq_pkg::PDATA_W-1:0] pwdata,
    output logic [tbq_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    tbq_in_if.sink                      sample_in,
    tbq_out_if.source                   result_out
);
    import tbq_pkg::*;

    tbq_cfg_t    cfg;
    tbq_status_t status;
    logic        in_xfer;

    tbq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbq_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample_in  (sample_in),
        .result_out (result_out),
        .status     (status)
    );

    assign in_xfer = sample_in.valid && sample_in.ready;

    `TBQ_ASSERT_NEXT(a_one_at_a_time, in_xfer, !sample_in.ready, "second sample taken while busy")
    `TBQ_ASSERT_NEXT(a_disabled_bypass, in_xfer && !cfg.enable, status.bypass_pend, "disabled sample not bypassed")
    `TBQ_ASSERT_NEXT(a_wb_then_idle, status.ram_we, status.idle, "no return to idle after write-back")
    `TBQ_ASSERT_NOW(a_no_bypass_write, status.ram_we, !status.bypass_pend, "bypassed sample wrote delay state")

endmodule

// ===== tb/sv/tb_three_axis_biquad_filter_top.sv =====
// testbench for the three-axis gyro biquad filter: directed and random samples, in-order checks
module tb_three_axis_biquad_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbq_pkg::*;

    localparam int QUIET_LIMIT    = 3000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_GAP        = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 145;
    localparam int STALL_SAMPLES  = 40;

    localparam logic [REG_IDX_W-1:0] UNUSED_REG_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] UNUSED_REG_HI = 3'd7;
    localparam logic [AXIS_W-1:0]    BAD_AXIS      = 2'd3;

    localparam logic [COEF_W-1:0] LANE_MAX  = 20'h7FFFF;
    localparam logic [COEF_W-1:0] LANE_MIN  = 20'h80000;
    localparam logic [COEF_W-1:0] LANE_HALF = 20'h10000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam longint DELAY_TOP    = (longint'(1) <<< (DELAY_W - 1)) - 1;
    localparam longint DELAY_BOTTOM = -(longint'(1) <<< (DELAY_W - 1));

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] rate;
        logic                       bypassed;
    } rate_result_t;

    typedef enum {COEFS_ANY, COEFS_MILD} coef_style_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tbq_in_if  sample_if ();
    tbq_out_if result_if ();

    three_axis_biquad_filter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_in  (sample_if),
        .result_out (result_if)
    );

    // filter settings and per-axis delay words as the block should hold them
    tbq_cfg_t     filt_cfg;
    longint       delay_first_q[AXES];
    longint       delay_second_q[AXES];
    rate_result_t expected_rates[$];

    int fail_count   = 0;
    int quiet_cycles = 0;
    int rx_hold      = 0;
    bit tx_idling    = 1'b1;
    bit rx_idling    = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint clamp_delay(input longint v);
        if (v > DELAY_TOP)
            return DELAY_TOP;
        if (v < DELAY_BOTTOM)
            return DELAY_BOTTOM;
        return v;
    endfunction

    // one step of the transposed direct form II section for the given axis
    function automatic rate_result_t filter_sample(
        input logic [AXIS_W-1:0]          axis,
        input logic signed [SAMPLE_W-1:0] x
    );
        rate_result_t r;
        longint       xs;
        longint       b0;
        longint       b1;
        longint       b2;
        longint       a1;
        longint       a2;
        longint       acc;
        longint       y;
        int           lane;

        xs = x;
        if (!filt_cfg.enable || axis >= AXES)
        begin
            r.rate     = x;
            r.bypassed = 1'b1;
            return r;
        end
        lane = axis * COEF_W;
        b0 = $signed(filt_cfg.b0[lane +: COEF_W]);
        b1 = $signed(filt_cfg.b1[lane +: COEF_W]);
        b2 = $signed(filt_cfg.b2[lane +: COEF_W]);
        a1 = $signed(filt_cfg.a1[lane +: COEF_W]);
        a2 = $signed(filt_cfg.a2[lane +: COEF_W]);

        acc = b0 * xs + delay_first_q[axis];
        // round half up, then floor shift back to sample units
        y = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (y > 32767)
            y = 32767;
        else if (y < -32768)
            y = -32768;

        delay_first_q[axis]  = clamp_delay(b1 * xs - a1 * y + delay_second_q[axis]);
        delay_second_q[axis] = clamp_delay(b2 * xs - a2 * y);

        r.rate     = y[SAMPLE_W-1:0];
        r.bypassed = 1'b0;
        return r;
    endfunction

    function automatic logic [PDATA_W-1:0] random_coef_word(
        input coef_style_t style,
        input int          limit
    );
        logic [PDATA_W-1:0] w;
        int                 v;
        int                 a;

        w = {$urandom, $urandom};
        if (style == COEFS_MILD)
        begin
            for (a = 0; a < AXES; a++)
            begin
                v = $urandom_range(0, 2 * limit) - limit;
                w[a*COEF_W +: COEF_W] = v[COEF_W-1:0];
            end
        end
        return w;
    endfunction

    task automatic flag_error(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] ERROR %s", $time, msg);
        fail_count++;
    endtask

    task automatic send_sample(
        input logic [AXIS_W-1:0]          axis,
        input logic signed [SAMPLE_W-1:0] x
    );
        int gap;

        gap = tx_idling ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid       <= 1'b1;
        sample_if.axis_sel    <= axis;
        sample_if.rate_sample <= x;
        do @(posedge clk); while (!sample_if.ready);
        expected_rates.push_back(filter_sample(axis, x));
    endtask

    task automatic send_random_sample();
        logic [AXIS_W-1:0]          axis;
        logic signed [SAMPLE_W-1:0] x;
        logic [31:0]                raw;

        raw  = $urandom;
        axis = ($urandom_range(0, 9) == 0) ? BAD_AXIS : AXIS_W'($urandom_range(0, AXES - 1));
        if ($urandom_range(0, 15) == 0)
            x = raw[16] ? SAMPLE_MAX : SAMPLE_MIN;
        else
            x = raw[SAMPLE_W-1:0];
        send_sample(axis, x);
    endtask

    // stop offering samples and wait for every outstanding result
    task automatic drain_results();
        sample_if.valid <= 1'b0;
        while (expected_rates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(
        input logic [REG_IDX_W-1:0] idx,
        input logic [PDATA_W-1:0]   data
    );
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE: filt_cfg.enable = data[0];
            REG_B0:     filt_cfg.b0 = data[COEF_REG_W-1:0];
            REG_B1:     filt_cfg.b1 = data[COEF_REG_W-1:0];
            REG_B2:     filt_cfg.b2 = data[COEF_REG_W-1:0];
            REG_A1:     filt_cfg.a1 = data[COEF_REG_W-1:0];
            REG_A2:     filt_cfg.a2 = data[COEF_REG_W-1:0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_filter(
        input logic [PDATA_W-1:0] en,
        input logic [PDATA_W-1:0] b0,
        input logic [PDATA_W-1:0] b1,
        input logic [PDATA_W-1:0] b2,
        input logic [PDATA_W-1:0] a1,
        input logic [PDATA_W-1:0] a2
    );
        drain_results();
        write_reg(REG_ENABLE, en);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
    endtask

    task automatic test_bypass_after_reset();
        send_sample(2'd0, SAMPLE_MAX);
        send_sample(2'd1, SAMPLE_MIN);
        send_sample(2'd2, 16'sd0);
        send_sample(BAD_AXIS, -16'sd1);
        send_sample(2'd0, 16'sh5555);
    endtask

    // reset coefficients give an identity filter; junk above bit 0 of enable is dropped
    task automatic test_identity_and_bad_axis();
        drain_results();
        write_reg(REG_ENABLE, {PDATA_W{1'b1}});
        send_sample(2'd0, SAMPLE_MIN);
        send_sample(2'd1, SAMPLE_MAX);
        send_sample(2'd2, -16'sd1);
        send_sample(BAD_AXIS, 16'sd12345);
        send_sample(2'd2, 16'sh2AAA);
    endtask

    task automatic test_output_saturation_and_rounding();
        load_filter(64'd1, {3{LANE_MAX}}, '0, '0, '0, '0);
        send_sample(2'd0, SAMPLE_MAX);
        send_sample(2'd1, SAMPLE_MIN);
        load_filter(64'd1, {3{LANE_MIN}}, '0, '0, '0, '0);
        send_sample(2'd2, SAMPLE_MAX);
        send_sample(2'd0, SAMPLE_MIN);
        // half-scale gain puts odd inputs exactly on the rounding boundary
        load_filter(64'd1, {3{LANE_HALF}}, '0, '0, '0, '0);
        send_sample(2'd1, 16'sd1);
        send_sample(2'd1, -16'sd1);
        send_sample(2'd1, 16'sd3);
        load_filter(64'd1, {3{LANE_MAX}}, {3{LANE_MIN}}, {3{LANE_MAX}},
                    {3{LANE_MAX}}, {3{LANE_MIN}});
        send_sample(2'd0, SAMPLE_MAX);
        send_sample(2'd0, SAMPLE_MIN);
        send_sample(2'd0, SAMPLE_MAX);
    endtask

    task automatic test_ignored_register_writes();
        load_filter(64'hFFFF_FFFF_FFFF_FFF1, {4'hF, {3{COEF_ONE}}}, {4'hA, 60'h0},
                    {4'h5, 60'h0}, {4'hC, 60'h0}, {4'h3, 60'h0});
        write_reg(UNUSED_REG_LO, {PDATA_W{1'b1}});
        write_reg(UNUSED_REG_HI, {PDATA_W{1'b1}});
        send_sample(2'd0, 16'sd100);
        send_sample(2'd1, -16'sd100);
        send_sample(2'd2, 16'sd7);
    endtask

    // the sink holds off while samples keep coming, then the source waits for all results
    task automatic test_stalled_receiver();
        int n;

        load_filter(64'd1, random_coef_word(COEFS_MILD, 1 << 16),
                    random_coef_word(COEFS_MILD, 1 << 16), random_coef_word(COEFS_MILD, 1 << 16),
                    random_coef_word(COEFS_MILD, 1 << 16), random_coef_word(COEFS_MILD, 1 << 15));
        tx_idling = 1'b0;
        rx_hold   = RX_HOLD_CYCLES;
        for (n = 0; n < STALL_SAMPLES; n++)
            send_random_sample();
        drain_results();
        tx_idling = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [PDATA_W-1:0] en;
        coef_style_t        style;
        int                 p;
        int                 n;

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            en    = {$urandom, $urandom};
            en[0] = (p != 4);
            style = (p % 3 == 2) ? COEFS_ANY : COEFS_MILD;
            if (p == 0)
                load_filter(en, '0, '0, '0, '0, '0);
            else if (p == 1)
                load_filter(en, '1, '1, '1, '1, '1);
            else
                load_filter(en, random_coef_word(style, 1 << 17),
                            random_coef_word(style, 1 << 16), random_coef_word(style, 1 << 16),
                            random_coef_word(style, 1 << 17), random_coef_word(style, 1 << 16));
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling = ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_SAMPLES; n++)
                send_random_sample();
        end
    endtask

    // result sink: a fresh stall draw after each transfer, or a long hold on request
    initial
    begin : result_sink
        int gap;

        gap = 0;
        result_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (result_if.valid && result_if.ready)
                gap = rx_idling ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold > 0)
            begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                gap--;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        rate_result_t want;
        rate_result_t got;

        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.rate     = result_if.filtered_rate;
            got.bypassed = result_if.bypassed;
            if (expected_rates.size() == 0)
            begin
                flag_error($sformatf("unexpected result rate %0d bypassed %0b",
                                     got.rate, got.bypassed));
            end
            else
            begin
                want = expected_rates.pop_front();
                if (got.rate !== want.rate)
                    flag_error($sformatf("filtered_rate expected %0d got %0d",
                                         want.rate, got.rate));
                if (got.bypassed !== want.bypassed)
                    flag_error($sformatf("bypassed expected %0b got %0b",
                                         want.bypassed, got.bypassed));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || psel || (sample_if.valid && sample_if.ready)
            || (result_if.valid && result_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : run_tests
        int a;

        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        sample_if.valid       = 1'b0;
        sample_if.axis_sel    = '0;
        sample_if.rate_sample = '0;

        filt_cfg        = '0;
        filt_cfg.enable = 1'b0;
        filt_cfg.b0     = COEF_B0_RST;
        for (a = 0; a < AXES; a++)
        begin
            delay_first_q[a]  = 0;
            delay_second_q[a] = 0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bypass_after_reset();
        test_identity_and_bad_axis();
        test_output_saturation_and_rounding();
        test_ignored_register_writes();
        test_stalled_receiver();
        test_random_phases();
        drain_results();

        if (expected_rates.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_rates.size()));
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
